/* rtl/msbt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the bag table.
package msbt_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response items
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // Width that holds both an index and a fill count for compares
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND    = 3'd0,
        KIND_INSERT    = 3'd1,
        KIND_COUNT     = 3'd2,
        KIND_ERASE_ONE = 3'd3,
        KIND_ERASE_ALL = 3'd4,
        KIND_READ      = 3'd5
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISSING  = 2'd2,
        ST_BADINDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;  // latch request, init pointers
        logic scan;     // count / erase scan over entries
        logic shift;    // move entries up for insert
        logic put;      // write the new value, bump fill
        logic rd;       // single entry read
        logic finish;   // commit fill count after an erase scan
        logic load;     // load response register
    } cmd_t;

    typedef struct packed {
        kind_t req_kind;
        logic  req_reject;
        logic  scan_done;
        logic  shift_done;
        logic  rsp_free;
    } sts_t;

endpackage

/* rtl/msbt_ctrl.sv */
// Sequencing state machine for the bag table.
module msbt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  msbt_pkg::sts_t  sts,
    output msbt_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PUT   = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (sts.req_kind)
                        msbt_pkg::KIND_APPEND,
                        msbt_pkg::KIND_INSERT:
                            state_next = sts.req_reject ? S_DONE : S_SHIFT;
                        msbt_pkg::KIND_COUNT,
                        msbt_pkg::KIND_ERASE_ONE,
                        msbt_pkg::KIND_ERASE_ALL:
                            state_next = S_SCAN;
                        msbt_pkg::KIND_READ:
                            state_next = sts.req_reject ? S_DONE : S_READ;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/msbt_dp.sv */
// Entry memory, scan and shift pointers, fill count and response register.
module msbt_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  msbt_pkg::cmd_t                        cmd,
    output msbt_pkg::sts_t                        sts,
    input  logic        [msbt_pkg::KIND_W-1:0]    kind,
    input  logic signed [msbt_pkg::DATA_W-1:0]    value,
    input  logic        [msbt_pkg::IDX_W-1:0]     index,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic        [msbt_pkg::STAT_W-1:0]    status,
    output logic signed [msbt_pkg::DATA_W-1:0]    read_value,
    output logic        [msbt_pkg::OCC_W-1:0]     match_count,
    output logic        [msbt_pkg::OCC_W-1:0]     occupancy
);

    logic [msbt_pkg::DATA_W-1:0] mem [msbt_pkg::DEPTH];
    logic [msbt_pkg::DATA_W-1:0] mem_q_reg;

    logic [msbt_pkg::CNT_W-1:0]  fill_reg;
    msbt_pkg::kind_t             op_reg;
    logic [msbt_pkg::DATA_W-1:0] value_reg;
    logic [msbt_pkg::CNT_W-1:0]  pos_reg;
    logic [msbt_pkg::CNT_W-1:0]  rd_ptr_reg;
    logic [msbt_pkg::CNT_W-1:0]  wr_ptr_reg;
    logic [msbt_pkg::CNT_W-1:0]  cnt_reg;
    logic                        found_reg;
    logic                        pv_reg;
    logic [msbt_pkg::ADDR_W-1:0] pidx_reg;
    msbt_pkg::status_t           err_reg;

    logic                        rsp_valid_reg;
    msbt_pkg::status_t           rsp_status_reg;
    logic [msbt_pkg::DATA_W-1:0] rsp_data_reg;
    logic [msbt_pkg::OCC_W-1:0]  rsp_match_reg;
    logic [msbt_pkg::OCC_W-1:0]  rsp_occ_reg;

    msbt_pkg::kind_t             req_kind;
    msbt_pkg::status_t           req_err;
    msbt_pkg::status_t           done_status;
    logic [msbt_pkg::CMP_W-1:0]  fill_cmp;
    logic [msbt_pkg::CMP_W-1:0]  idx_cmp;
    logic                        is_full;
    logic                        is_erase;
    logic                        match;
    logic                        keep;
    logic                        scan_issue;
    logic                        shift_issue;
    logic                        scan_wr;
    logic                        rd_en;
    logic [msbt_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [msbt_pkg::ADDR_W-1:0] wr_addr;
    logic [msbt_pkg::DATA_W-1:0] wr_data;

    // request checks against the current fill count
    assign req_kind = msbt_pkg::kind_t'(kind);
    assign fill_cmp = msbt_pkg::CMP_W'(fill_reg);
    assign idx_cmp  = msbt_pkg::CMP_W'(index);
    assign is_full  = (fill_reg == msbt_pkg::CNT_W'(msbt_pkg::DEPTH));

    always_comb
    begin
        unique case (req_kind)
            msbt_pkg::KIND_APPEND:
                req_err = is_full ? msbt_pkg::ST_FULL : msbt_pkg::ST_OK;
            msbt_pkg::KIND_INSERT:
            begin
                priority if (is_full)
                    req_err = msbt_pkg::ST_FULL;
                else if (idx_cmp > fill_cmp)
                    req_err = msbt_pkg::ST_BADINDEX;
                else
                    req_err = msbt_pkg::ST_OK;
            end
            msbt_pkg::KIND_READ:
                req_err = (idx_cmp >= fill_cmp) ? msbt_pkg::ST_BADINDEX : msbt_pkg::ST_OK;
            default:
                req_err = msbt_pkg::ST_OK;
        endcase
    end

    assign is_erase = (op_reg == msbt_pkg::KIND_ERASE_ONE) ||
                      (op_reg == msbt_pkg::KIND_ERASE_ALL);

    // scan stage: compare the entry read last cycle
    assign match = cmd.scan && pv_reg && (mem_q_reg == value_reg);
    assign keep  = (op_reg == msbt_pkg::KIND_ERASE_ONE) ? !(match && !found_reg) : !match;

    assign scan_issue  = cmd.scan && (rd_ptr_reg < fill_reg);
    assign shift_issue = cmd.shift && (rd_ptr_reg > pos_reg);
    assign scan_wr     = cmd.scan && pv_reg && is_erase && keep;

    assign sts.req_kind   = req_kind;
    assign sts.req_reject = (req_err != msbt_pkg::ST_OK);
    assign sts.scan_done  = (rd_ptr_reg == fill_reg) && !pv_reg;
    assign sts.shift_done = (rd_ptr_reg == pos_reg) && !pv_reg;
    assign sts.rsp_free   = !rsp_valid_reg || !rsp_stall;

    // memory port selection
    always_comb
    begin
        rd_en   = scan_issue || shift_issue || cmd.rd;
        rd_addr = rd_ptr_reg[msbt_pkg::ADDR_W-1:0];
        if (shift_issue)
            rd_addr = msbt_pkg::ADDR_W'(rd_ptr_reg - msbt_pkg::CNT_W'(1));
        else if (cmd.rd)
            rd_addr = pos_reg[msbt_pkg::ADDR_W-1:0];

        wr_en   = 1'b0;
        wr_addr = wr_ptr_reg[msbt_pkg::ADDR_W-1:0];
        wr_data = mem_q_reg;
        if (scan_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift && pv_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = msbt_pkg::ADDR_W'(msbt_pkg::CNT_W'(pidx_reg) + msbt_pkg::CNT_W'(1));
        end
        else if (cmd.put)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[msbt_pkg::ADDR_W-1:0];
            wr_data = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        unique case (op_reg)
            msbt_pkg::KIND_ERASE_ONE:
                done_status = found_reg ? msbt_pkg::ST_OK : msbt_pkg::ST_MISSING;
            msbt_pkg::KIND_ERASE_ALL:
                done_status = (cnt_reg == '0) ? msbt_pkg::ST_MISSING : msbt_pkg::ST_OK;
            default:
                done_status = err_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            pv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // no issue on a capture cycle, so the pipe is empty at the start
            pv_reg <= scan_issue || shift_issue;
            if (cmd.capture)
            begin
                rd_ptr_reg <= ((req_kind == msbt_pkg::KIND_APPEND) ||
                               (req_kind == msbt_pkg::KIND_INSERT)) ? fill_reg : '0;
                wr_ptr_reg <= '0;
                cnt_reg    <= '0;
                found_reg  <= 1'b0;
            end
            if (scan_issue)
                rd_ptr_reg <= rd_ptr_reg + msbt_pkg::CNT_W'(1);
            if (shift_issue)
                rd_ptr_reg <= rd_ptr_reg - msbt_pkg::CNT_W'(1);
            if (scan_wr)
                wr_ptr_reg <= wr_ptr_reg + msbt_pkg::CNT_W'(1);
            if (match)
            begin
                cnt_reg   <= cnt_reg + msbt_pkg::CNT_W'(1);
                found_reg <= 1'b1;
            end
            if (cmd.finish && is_erase)
                fill_reg <= wr_ptr_reg;
            if (cmd.put)
                fill_reg <= fill_reg + msbt_pkg::CNT_W'(1);

            if (cmd.load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= req_kind;
            value_reg <= value;
            pos_reg   <= (req_kind == msbt_pkg::KIND_APPEND) ? fill_reg
                                                             : msbt_pkg::CNT_W'(idx_cmp);
            err_reg   <= req_err;
        end
        if (shift_issue)
            pidx_reg <= msbt_pkg::ADDR_W'(rd_ptr_reg - msbt_pkg::CNT_W'(1));
        if (cmd.load)
        begin
            rsp_status_reg <= done_status;
            rsp_data_reg   <= ((op_reg == msbt_pkg::KIND_READ) && (err_reg == msbt_pkg::ST_OK))
                              ? mem_q_reg : '0;
            rsp_match_reg  <= ((op_reg == msbt_pkg::KIND_COUNT) ||
                               (op_reg == msbt_pkg::KIND_ERASE_ALL))
                              ? msbt_pkg::OCC_W'(cnt_reg) : '0;
            rsp_occ_reg    <= msbt_pkg::OCC_W'(fill_reg);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign read_value  = rsp_data_reg;
    assign match_count = rsp_match_reg;
    assign occupancy   = rsp_occ_reg;

endmodule

/* rtl/multiset_bag_table.sv */
// Top level of the bag table: request/response channels, controller and datapath.
//
// A bag of up to DEPTH (64) signed 32-bit values held as a packed list in a
// single-port-read, single-port-write memory. One request item is taken at a
// time: append, insert at index, count, erase one, erase all, or read. Every
// request returns exactly one response item with a status, the read value,
// a match count and the occupancy after the operation. With n = fill count,
// count and both erases walk all n entries; an insert at index i moves
// d = n - i entries up, and nothing moves for an append or an insert at
// the end; rejected requests and unused kinds go straight to the response.
// A stalled response adds its stall on top only when a later item is ready
// to load behind it. The entry memory moves one entry per cycle. A response
// waits in its own register, so the next request is taken while it is stalled.
// No clearing pass after reset: only entries below the fill count are read.
module multiset_bag_table (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic        [msbt_pkg::KIND_W-1:0]    kind,
    input  logic signed [msbt_pkg::DATA_W-1:0]    value,
    input  logic        [msbt_pkg::IDX_W-1:0]     index,
    // response channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic        [msbt_pkg::STAT_W-1:0]    status,
    output logic signed [msbt_pkg::DATA_W-1:0]    read_value,
    output logic        [msbt_pkg::OCC_W-1:0]     match_count,
    output logic        [msbt_pkg::OCC_W-1:0]     occupancy
);

    msbt_pkg::cmd_t cmd;
    msbt_pkg::sts_t sts;

    // Controller: accepts a request only in its idle state and steps the
    // datapath through scan, shift, write, read and response load.
    msbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: entry memory with registered read data feeding the
    // compare/write pipeline, fill count and the response register.
    msbt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .value       (value),
        .index       (index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .read_value  (read_value),
        .match_count (match_count),
        .occupancy   (occupancy)
    );

endmodule

/* rtl/msbt_checker.sv */
// Port-level assertions for the bag table, bound to the top level.
module msbt_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  rsp_valid,
    input logic                                  rsp_stall,
    input logic        [msbt_pkg::STAT_W-1:0]    status,
    input logic signed [msbt_pkg::DATA_W-1:0]    read_value,
    input logic        [msbt_pkg::OCC_W-1:0]     match_count,
    input logic        [msbt_pkg::OCC_W-1:0]     occupancy
);

    // stalled response stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (occupancy <= msbt_pkg::OCC_W'(msbt_pkg::DEPTH)))
        else $error("occupancy beyond capacity");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == msbt_pkg::ST_FULL) |->
            (occupancy == msbt_pkg::OCC_W'(msbt_pkg::DEPTH)))
        else $error("full status with room left");

    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (match_count != '0) |->
            (status == msbt_pkg::ST_OK) && (read_value == '0))
        else $error("match count with error status or read data");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_value != '0) |->
            (status == msbt_pkg::ST_OK) && (occupancy != '0))
        else $error("read data with error status or empty table");

endmodule

bind multiset_bag_table msbt_checker u_msbt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .read_value  (read_value),
    .match_count (match_count),
    .occupancy   (occupancy)
);

/* bench/tb.sv */
// Self-checking bench for the bag table: request driver, response monitor and contents predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds 6 and 7 are spare codes: no package member, the block must answer ok and change nothing
    localparam logic [msbt_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [msbt_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int MAX_WAIT     = 12;    // longest gap / stall drawn per item
    localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake before giving up
    localparam int TAIL_CYCLES  = 100;   // settle time after the last response
    localparam int ITEM_TARGET  = 675;   // directed items plus about 650 random ones
    localparam int POOL_SIZE    = 6;

    typedef struct {
        logic [msbt_pkg::KIND_W-1:0] kind;
        logic [msbt_pkg::DATA_W-1:0] value;
        logic [msbt_pkg::IDX_W-1:0]  index;
    } request_t;

    typedef struct {
        logic [msbt_pkg::STAT_W-1:0] status;
        logic [msbt_pkg::DATA_W-1:0] read_value;
        logic [msbt_pkg::OCC_W-1:0]  match_count;
        logic [msbt_pkg::OCC_W-1:0]  occupancy;
    } answer_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_stall;
    logic        [msbt_pkg::KIND_W-1:0] kind = '0;
    logic signed [msbt_pkg::DATA_W-1:0] value = '0;
    logic        [msbt_pkg::IDX_W-1:0]  index = '0;
    logic                               rsp_valid;
    logic                               rsp_stall = 1'b0;
    logic        [msbt_pkg::STAT_W-1:0] status;
    logic signed [msbt_pkg::DATA_W-1:0] read_value;
    logic        [msbt_pkg::OCC_W-1:0]  match_count;
    logic        [msbt_pkg::OCC_W-1:0]  occupancy;

    // Items waiting for the driver, and answers waiting for the monitor
    request_t request_q[$];
    answer_t  answer_q[$];

    // Predicted table contents; only entries below bag_fill are meaningful
    logic [msbt_pkg::DATA_W-1:0] bag_mem [msbt_pkg::DEPTH];
    int                          bag_fill = 0;

    // Small set of values reused per round so counts and erases actually hit
    logic [msbt_pkg::DATA_W-1:0] value_pool [POOL_SIZE];

    bit req_busy = 1'b1;   // sender inserts random gaps
    bit rsp_busy = 1'b1;   // receiver inserts random stalls
    int req_gap = 0;
    int rsp_hold = 0;
    int idle_cycles = 0;
    int issued_n = 0;
    bit failed = 1'b0;

    multiset_bag_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .value       (value),
        .index       (index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .read_value  (read_value),
        .match_count (match_count),
        .occupancy   (occupancy)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one accepted request to the predicted table and queue the answer it must produce.
    function automatic void bag_apply(input request_t rq);
        answer_t a;
        int      i;
        int      w;
        int      hit;
        int      n;
        a.status      = msbt_pkg::ST_OK;
        a.read_value  = '0;
        a.match_count = '0;
        n             = 0;
        case (rq.kind)
            msbt_pkg::KIND_APPEND:
            begin
                if (bag_fill >= msbt_pkg::DEPTH)
                    a.status = msbt_pkg::ST_FULL;
                else
                begin
                    bag_mem[bag_fill] = rq.value;
                    bag_fill++;
                end
            end
            msbt_pkg::KIND_INSERT:
            begin
                // full check wins over the index check
                if (bag_fill >= msbt_pkg::DEPTH)
                    a.status = msbt_pkg::ST_FULL;
                else if (int'(rq.index) > bag_fill)
                    a.status = msbt_pkg::ST_BADINDEX;
                else
                begin
                    for (i = bag_fill; i > int'(rq.index); i--)
                        bag_mem[i] = bag_mem[i - 1];
                    bag_mem[rq.index] = rq.value;
                    bag_fill++;
                end
            end
            msbt_pkg::KIND_COUNT:
            begin
                for (i = 0; i < bag_fill; i++)
                    if (bag_mem[i] == rq.value)
                        n++;
            end
            msbt_pkg::KIND_ERASE_ONE:
            begin
                hit = -1;
                for (i = 0; i < bag_fill; i++)
                    if (hit < 0 && bag_mem[i] == rq.value)
                        hit = i;
                if (hit < 0)
                    a.status = msbt_pkg::ST_MISSING;
                else
                begin
                    for (i = hit; i < bag_fill - 1; i++)
                        bag_mem[i] = bag_mem[i + 1];
                    bag_fill--;
                end
            end
            msbt_pkg::KIND_ERASE_ALL:
            begin
                w = 0;
                for (i = 0; i < bag_fill; i++)
                begin
                    if (bag_mem[i] == rq.value)
                        n++;
                    else
                    begin
                        bag_mem[w] = bag_mem[i];
                        w++;
                    end
                end
                bag_fill = w;
                if (n == 0)
                    a.status = msbt_pkg::ST_MISSING;
            end
            msbt_pkg::KIND_READ:
            begin
                if (int'(rq.index) >= bag_fill)
                    a.status = msbt_pkg::ST_BADINDEX;
                else
                    a.read_value = bag_mem[rq.index];
            end
            default:
            begin
                // spare kinds: plain ok, nothing touched
            end
        endcase
        a.match_count = msbt_pkg::OCC_W'(n);
        a.occupancy   = msbt_pkg::OCC_W'(bag_fill);
        answer_q.push_back(a);
    endfunction

    // Driver: presents one item at a time, holds it while stalled, then waits its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            kind      <= '0;
            value     <= '0;
            index     <= '0;
            req_gap   <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                rq.kind  = kind;
                rq.value = value;
                rq.index = index;
                bag_apply(rq);
            end
            if (req_valid && req_stall)
            begin
                // stalled: payload and valid stay as they are
            end
            else if (req_gap != 0)
            begin
                req_gap   <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                rq        = request_q.pop_front();
                kind      <= rq.kind;
                value     <= rq.value;
                index     <= rq.index;
                req_valid <= 1'b1;
                req_gap   <= req_busy ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Monitor: checks every accepted response against the oldest answer, and draws
    // a stall length for the next response that only runs down while valid is up.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      hold_next;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else
        begin
            hold_next = rsp_hold;
            if (rsp_valid && !rsp_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected response item: status %0d occupancy %0d",
                           status, occupancy);
                    failed = 1'b1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failed = 1'b1;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0h, got %0h",
                               want.read_value, read_value);
                        failed = 1'b1;
                    end
                    if (match_count !== want.match_count)
                    begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, match_count);
                        failed = 1'b1;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, occupancy);
                        failed = 1'b1;
                    end
                end
                hold_next = rsp_busy ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (rsp_valid && hold_next != 0)
                hold_next--;
            rsp_hold  <= hold_next;
            rsp_stall <= (hold_next != 0);
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Hand one item to the driver; keeps at most one item queued so the
    // generator sees a nearly current fill level when shaping the next one.
    task automatic send(input logic [msbt_pkg::KIND_W-1:0] k,
                        input logic [msbt_pkg::DATA_W-1:0] v,
                        input logic [msbt_pkg::IDX_W-1:0] ix);
        request_t rq;
        while (request_q.size() != 0)
            @(posedge clk);
        rq.kind  = k;
        rq.value = v;
        rq.index = ix;
        request_q.push_back(rq);
        issued_n++;
    endtask

    function automatic logic [msbt_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Any index over the full range; ignored by most kinds
    function automatic logic [msbt_pkg::IDX_W-1:0] any_index();
        return msbt_pkg::IDX_W'($urandom_range(0, msbt_pkg::DEPTH - 1));
    endfunction

    function automatic logic [msbt_pkg::IDX_W-1:0] insert_index();
        int top;
        top = (bag_fill < msbt_pkg::DEPTH - 1) ? bag_fill : msbt_pkg::DEPTH - 1;
        if ($urandom_range(0, 9) == 0)
            return any_index();
        return msbt_pkg::IDX_W'($urandom_range(0, top));
    endfunction

    function automatic logic [msbt_pkg::IDX_W-1:0] read_index();
        if (bag_fill == 0 || $urandom_range(0, 9) == 0)
            return any_index();
        return msbt_pkg::IDX_W'($urandom_range(0, bag_fill - 1));
    endfunction

    initial
    begin
        int target;
        int steps;
        int r;
        int p;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: empty-table corner cases ----
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd0);    // read of empty table
        send(msbt_pkg::KIND_ERASE_ONE, 32'h0000_0005, 6'd0);    // erase-one miss
        send(msbt_pkg::KIND_ERASE_ALL, 32'h0000_0005, 6'd0);    // erase-all miss, count 0
        send(msbt_pkg::KIND_COUNT,     32'h0000_0005, 6'd0);    // count of nothing is still ok
        send(msbt_pkg::KIND_INSERT,    32'h1234_5678, 6'd1);    // insert past the end
        // ---- build a small table with the value extremes ----
        send(msbt_pkg::KIND_INSERT,    32'h8000_0000, 6'd0);    // insert at end of empty table
        send(msbt_pkg::KIND_APPEND,    32'h7fff_ffff, 6'd0);
        send(msbt_pkg::KIND_APPEND,    32'hffff_ffff, 6'd0);
        send(msbt_pkg::KIND_APPEND,    32'h0000_0000, 6'd0);
        send(msbt_pkg::KIND_INSERT,    32'h7fff_ffff, 6'd4);    // index equal to fill appends
        send(msbt_pkg::KIND_INSERT,    32'h5555_5555, 6'd2);    // shift in the middle
        send(msbt_pkg::KIND_COUNT,     32'h7fff_ffff, 6'd0);
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd0);
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd5);    // last entry
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd6);    // one past the end
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd63);
        send(msbt_pkg::KIND_ERASE_ONE, 32'h7fff_ffff, 6'd0);    // first of two copies goes
        send(msbt_pkg::KIND_ERASE_ONE, 32'h0001_2345, 6'd0);
        send(msbt_pkg::KIND_ERASE_ALL, 32'h7fff_ffff, 6'd0);
        send(msbt_pkg::KIND_ERASE_ALL, 32'h7fff_ffff, 6'd0);    // nothing left to remove
        send(KIND_SPARE_LO,            32'haaaa_aaaa, 6'd21);
        send(KIND_SPARE_HI,            32'h5555_5555, 6'd42);
        send(msbt_pkg::KIND_READ,      32'h0000_0000, 6'd3);

        // ---- random rounds: grow to a target, mix operations, sometimes drain ----
        while (issued_n < ITEM_TARGET)
        begin
            req_busy = ($urandom_range(0, 3) != 0);
            rsp_busy = ($urandom_range(0, 3) != 0);
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
            for (p = 2; p < POOL_SIZE; p++)
                value_pool[p] = ($urandom_range(0, 3) == 0) ?
                                {msbt_pkg::DATA_W{$urandom_range(0, 1) == 1}} : $urandom;

            // most rounds stay small; a quarter run the table all the way to full
            target = ($urandom_range(0, 3) == 0) ? msbt_pkg::DEPTH : $urandom_range(0, 40);
            steps  = 0;
            while (bag_fill < target)
            begin
                if ($urandom_range(0, 1) == 0)
                    send(msbt_pkg::KIND_APPEND, pick_value(), any_index());
                else
                    send(msbt_pkg::KIND_INSERT, pick_value(),
                         msbt_pkg::IDX_W'($urandom_range(0, bag_fill)));
                steps++;
            end

            if (target == msbt_pkg::DEPTH)
            begin
                // full table: append and insert are refused as full, last slot readable
                send(msbt_pkg::KIND_APPEND, pick_value(), 6'd0);
                send(msbt_pkg::KIND_INSERT, pick_value(), 6'd63);
                send(msbt_pkg::KIND_INSERT, pick_value(), any_index());
                send(msbt_pkg::KIND_READ,   32'h0000_0000, 6'd63);
                send(msbt_pkg::KIND_READ,   32'h0000_0000, 6'd0);
                send(msbt_pkg::KIND_COUNT,  pick_value(), 6'd0);
            end

            steps = $urandom_range(15, 40);
            repeat (steps)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    send(msbt_pkg::KIND_APPEND, pick_value(), any_index());
                else if (r < 30)
                    send(msbt_pkg::KIND_INSERT, pick_value(), insert_index());
                else if (r < 48)
                    send(msbt_pkg::KIND_COUNT, pick_value(), any_index());
                else if (r < 63)
                    send(msbt_pkg::KIND_ERASE_ONE, pick_value(), any_index());
                else if (r < 71)
                    send(msbt_pkg::KIND_ERASE_ALL, pick_value(), any_index());
                else if (r < 96)
                    send(msbt_pkg::KIND_READ, $urandom, read_index());
                else
                    send(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI,
                         $urandom, any_index());
            end

            // occasional drain so the next round starts from a small table
            if ($urandom_range(0, 2) == 0)
                for (p = 0; p < POOL_SIZE; p++)
                    send(msbt_pkg::KIND_ERASE_ALL, value_pool[p], 6'd0);
        end

        // all items handed over, accepted, and answered
        while (request_q.size() != 0 || req_valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/msbt_pkg.sv
rtl/msbt_ctrl.sv
rtl/msbt_dp.sv
rtl/multiset_bag_table.sv
rtl/msbt_checker.sv
bench/tb.sv
